// ----- rtl/utf8_sequence_decoder_unit_assert.svh -----
// ---------------------------------------------------------------------------
// UTF-8 sequence decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_SEQUENCE_DECODER_UNIT_ASSERT_SVH
`define UTF8_SEQUENCE_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define UTF8SD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utf8 decoder: same-cycle check failed");

// next-cycle implication
`define UTF8SD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utf8 decoder: next-cycle check failed");

`endif

// ----- rtl/utf8sd_pkg.sv -----
// ---------------------------------------------------------------------------
// UTF-8 sequence decoder package
// Status codes, field widths and byte range constants.
// ---------------------------------------------------------------------------
package utf8sd_pkg;

	localparam int unsigned CpW    = 21;
	localparam int unsigned ClassW = 3;
	localparam int unsigned OwedW  = 2;

	typedef enum logic [2:0] {
		ST_PENDING  = 3'd0,
		ST_DONE     = 3'd1,
		ST_BAD_LEAD = 3'd2,
		ST_BAD_CONT = 3'd3,
		ST_BAD_LEN  = 3'd4,
		ST_RANGE    = 3'd5
	} status_t;

	localparam logic [7:0]     ASCII_MAX  = 8'h7F;
	localparam logic [7:0]     LEAD2_MIN  = 8'hC2;
	localparam logic [7:0]     LEAD2_MAX  = 8'hDF;
	localparam logic [7:0]     LEAD3_MAX  = 8'hEF;
	localparam logic [7:0]     LEAD4_MAX  = 8'hF4;
	localparam logic [7:0]     CONT_MIN   = 8'h80;
	localparam logic [7:0]     CONT_MAX   = 8'hBF;
	localparam logic [CpW-1:0] SCALAR_MAX = 21'h10FFFF;
	localparam logic [CpW-1:0] CP1_MAX    = 21'h00007F;
	localparam logic [CpW-1:0] CP2_MAX    = 21'h0007FF;
	localparam logic [CpW-1:0] CP3_MAX    = 21'h00FFFF;

	typedef struct packed {
		logic [CpW-1:0]    code_point;
		logic [ClassW-1:0] length_class;
		status_t           status;
		logic [CpW-1:0]    partial;
		logic [OwedW-1:0]  owed;
	} step_res_t;

endpackage

// ----- rtl/utf8_sequence_decoder_unit.sv -----
// Path: a byte accepted into the input register goes through the decode step into
// the result register, which drives the outputs.
// Throughput: one byte per cycle; a held result stalls the input stage only
// when the result register is full and out_stall is high.
// Reset: arst_n clears the stage valids, the partial value and the owed
// count, leaving the decoder idle with no result shown.
// ---------------------------------------------------------------------------
// UTF-8 sequence decoder unit
// Input register, one decode step, result register; one status per byte.
// ---------------------------------------------------------------------------
`include "utf8_sequence_decoder_unit_assert.svh"

module utf8_sequence_decoder_unit
	import utf8sd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              seq_end,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CpW-1:0]    code_point,
	output logic [ClassW-1:0] length_class,
	output logic [2:0]        status
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             end_s1;
	logic             valid_s2;
	step_res_t        res_s2;
	logic [CpW-1:0]   partial_q;
	logic [OwedW-1:0] owed_q;
	step_res_t        res;
	logic             s2_free;
	logic             adv_s1;

	assign s2_free  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;

	utf8sd_step u_step (
		.in_byte (byte_s1),
		.seq_end (end_s1),
		.partial (partial_q),
		.owed    (owed_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			end_s1  <= seq_end;
		end
	end

	// advance decoder state as each request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			partial_q <= '0;
			owed_q    <= '0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				partial_q <= res.partial;
				owed_q    <= res.owed;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign code_point   = res_s2.code_point;
	assign length_class = res_s2.length_class;
	assign status       = res_s2.status;

	`UTF8SD_ASSERT_NOW(a_idle_clear, owed_q == '0, partial_q == '0)
	`UTF8SD_ASSERT_NEXT(a_final_idle, adv_s1 && res.status != ST_PENDING, owed_q == '0)
	`UTF8SD_ASSERT_NOW(a_not_done_zero, valid_s2 && res_s2.status != ST_DONE,
		code_point == '0 && length_class == '0)
	`UTF8SD_ASSERT_NOW(a_done_class, valid_s2 && res_s2.status == ST_DONE,
		length_class != '0 && code_point <= SCALAR_MAX)

endmodule

// ----- rtl/utf8sd_step.sv -----
// ---------------------------------------------------------------------------
// UTF-8 decode step
// Classifies one byte against the current partial value and owed count and
// produces the result fields and the next decoder state.
// ---------------------------------------------------------------------------
module utf8sd_step
	import utf8sd_pkg::*;
(
	input  logic [7:0]       in_byte,
	input  logic             seq_end,
	input  logic [CpW-1:0]   partial,
	input  logic [OwedW-1:0] owed,
	output step_res_t        res
);

	logic [CpW-1:0] merged;

	assign merged = partial | {15'd0, in_byte[5:0]};

	always_comb begin
		res = '0;
		res.status = ST_PENDING;
		if (owed == '0) begin
			if (in_byte <= ASCII_MAX) begin
				if (seq_end) begin
					res.status     = ST_DONE;
					res.code_point = {13'd0, in_byte};
				end else begin
					res.status = ST_BAD_LEN;
				end
			end else if (!(in_byte inside {[LEAD2_MIN:LEAD4_MAX]})) begin
				res.status = ST_BAD_LEAD;
			end else if (seq_end) begin
				res.status = ST_BAD_LEN;
			end else if (in_byte <= LEAD2_MAX) begin
				res.partial = {10'd0, in_byte[4:0], 6'd0};
				res.owed    = 2'd1;
			end else if (in_byte <= LEAD3_MAX) begin
				res.partial = {11'd0, in_byte[3:0], 6'd0};
				res.owed    = 2'd2;
			end else begin
				res.partial = {12'd0, in_byte[2:0], 6'd0};
				res.owed    = 2'd3;
			end
		end else if (seq_end != (owed == 2'd1)) begin
			res.status = ST_BAD_LEN;
		end else if (!(in_byte inside {[CONT_MIN:CONT_MAX]})) begin
			res.status = ST_BAD_CONT;
		end else if (owed == 2'd1) begin
			if (merged > SCALAR_MAX) begin
				res.status = ST_RANGE;
			end else begin
				res.status     = ST_DONE;
				res.code_point = merged;
			end
		end else begin
			res.partial = {merged[CpW-7:0], 6'd0};
			res.owed    = owed - 2'd1;
		end

		// class by value range, only for a finished code point
		if (res.status == ST_DONE) begin
			if (res.code_point <= CP1_MAX) begin
				res.length_class = 3'd1;
			end else if (res.code_point <= CP2_MAX) begin
				res.length_class = 3'd2;
			end else if (res.code_point <= CP3_MAX) begin
				res.length_class = 3'd3;
			end else begin
				res.length_class = 3'd4;
			end
		end
	end

endmodule

// ----- tb/utf8_decoder_checker.sv -----
// ---------------------------------------------------------------------------
// UTF-8 sequence decoder checker
// Watches both channels of the decoder. Each accepted request goes through a
// local decode model, and the result it predicts is queued. Each accepted
// result is compared field by field with the oldest queued prediction.
// ---------------------------------------------------------------------------
module utf8_decoder_checker
	import utf8sd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              seq_end,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [CpW-1:0]    code_point,
	input  logic [ClassW-1:0] length_class,
	input  logic [2:0]        status,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [CpW-1:0]    code_point;
		logic [ClassW-1:0] length_class;
		status_t           status;
	} decoded_t;

	decoded_t         awaited_q[$];
	logic [CpW-1:0]   acc_value;
	logic [OwedW-1:0] owed_count;
	int               errors = 0;
	int               in_flight = 0;

	assign fail_count = errors;
	assign pending    = in_flight;

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
		errors++;
	endtask

	function automatic decoded_t finish_value(input logic [CpW-1:0] v);
		decoded_t r;
		r = '0;
		if (v > SCALAR_MAX) begin
			r.status = ST_RANGE;
		end else begin
			r.status     = ST_DONE;
			r.code_point = v;
			if (v <= CP1_MAX)
				r.length_class = 3'd1;
			else if (v <= CP2_MAX)
				r.length_class = 3'd2;
			else if (v <= CP3_MAX)
				r.length_class = 3'd3;
			else
				r.length_class = 3'd4;
		end
		return r;
	endfunction

	// Advance the local decode state by one byte; every error or done drops to idle.
	function automatic decoded_t decode_step(input logic [7:0] b, input logic last);
		decoded_t         r;
		logic [CpW-1:0]   v;
		logic [CpW-1:0]   nxt_acc;
		logic [OwedW-1:0] nxt_owed;
		r        = '0;
		r.status = ST_PENDING;
		nxt_acc  = '0;
		nxt_owed = '0;
		if (owed_count == '0) begin
			if (b <= ASCII_MAX) begin
				if (last)
					r = finish_value(CpW'(b));
				else
					r.status = ST_BAD_LEN;
			end else if (b < LEAD2_MIN || b > LEAD4_MAX) begin
				r.status = ST_BAD_LEAD;
			end else if (last) begin
				r.status = ST_BAD_LEN;
			end else if (b <= LEAD2_MAX) begin
				nxt_acc  = CpW'(b[4:0]) << 6;
				nxt_owed = 2'd1;
			end else if (b <= LEAD3_MAX) begin
				nxt_acc  = CpW'(b[3:0]) << 6;
				nxt_owed = 2'd2;
			end else begin
				nxt_acc  = CpW'(b[2:0]) << 6;
				nxt_owed = 2'd3;
			end
		end else if (last != (owed_count == 2'd1)) begin
			// length is judged before the byte itself
			r.status = ST_BAD_LEN;
		end else if (b < CONT_MIN || b > CONT_MAX) begin
			r.status = ST_BAD_CONT;
		end else begin
			v = acc_value | CpW'(b[5:0]);
			if (owed_count == 2'd1) begin
				r = finish_value(v);
			end else begin
				nxt_acc  = v << 6;
				nxt_owed = owed_count - 2'd1;
			end
		end
		acc_value  = nxt_acc;
		owed_count = nxt_owed;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			acc_value  = '0;
			owed_count = '0;
			awaited_q.delete();
			in_flight  = 0;
		end else begin
			// take the result first so a request accepted now cannot cover for it
			if (out_valid && !out_stall) begin
				if (awaited_q.size() == 0) begin
					report_mismatch("unrequested result, status", 0, status);
				end else begin
					want = awaited_q.pop_front();
					if (code_point !== want.code_point)
						report_mismatch("code_point", want.code_point, code_point);
					if (length_class !== want.length_class)
						report_mismatch("length_class", want.length_class, length_class);
					if (status !== want.status)
						report_mismatch("status", want.status, status);
				end
			end
			if (in_valid && !in_stall)
				awaited_q.push_back(decode_step(in_byte, seq_end));
			in_flight = awaited_q.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// UTF-8 sequence decoder testbench
// Feeds directed byte sequences covering every status, then a random stream
// of mostly well-formed sequences with broken ones and noise mixed in, while
// both channels idle and stall at random. The checker does the comparison.
// ---------------------------------------------------------------------------
module testbench
	import utf8sd_pkg::*;
();

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        in_byte;
	logic              seq_end;
	logic              out_valid;
	logic              out_stall;
	logic [CpW-1:0]    code_point;
	logic [ClassW-1:0] length_class;
	logic [2:0]        status;
	int                fail_count;
	int                pending;

	logic [7:0] stream_bytes[$];
	logic       stream_ends[$];

	utf8_sequence_decoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.seq_end      (seq_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_point   (code_point),
		.length_class (length_class),
		.status       (status)
	);

	utf8_decoder_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.seq_end      (seq_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.code_point   (code_point),
		.length_class (length_class),
		.status       (status),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	function automatic void push_byte(input logic [7:0] b, input logic last);
		stream_bytes.push_back(b);
		stream_ends.push_back(last);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: random stalls, one long hold-off to back the pipe up, one calm stretch.
	initial begin
		int cyc;
		cyc = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= 150 && cyc < 240)
				out_stall <= 1'b1;
			else if (cyc >= 900 && cyc < 1200)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(0, 99) < 26);
		end
	end

	initial begin
		int         kind;
		int         len;
		int         cut;
		logic [7:0] seq_b[4];
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_byte  <= 8'h00;
		seq_end  <= 1'b0;

		// ASCII extremes, unflagged ASCII, bad leads
		push_byte(8'h00, 1'b1);
		push_byte(8'h7F, 1'b1);
		push_byte(8'h41, 1'b0);
		push_byte(8'h80, 1'b1);
		push_byte(8'hC1, 1'b0);
		push_byte(8'hFF, 1'b1);
		// two-byte extremes, a surrogate, top scalar, just past it
		push_byte(8'hC2, 1'b0); push_byte(8'h80, 1'b1);
		push_byte(8'hDF, 1'b0); push_byte(8'hBF, 1'b1);
		push_byte(8'hED, 1'b0); push_byte(8'hA0, 1'b0); push_byte(8'h80, 1'b1);
		push_byte(8'hF4, 1'b0); push_byte(8'h8F, 1'b0); push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b1);
		push_byte(8'hF4, 1'b0); push_byte(8'h90, 1'b0); push_byte(8'h80, 1'b0);
		push_byte(8'h80, 1'b1);
		// flagged lead, flagged early, bad continuation, last byte unflagged
		push_byte(8'hC2, 1'b1);
		push_byte(8'hE0, 1'b0); push_byte(8'h80, 1'b1);
		push_byte(8'hC2, 1'b0); push_byte(8'hC0, 1'b1);
		push_byte(8'hE0, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);

		while (stream_bytes.size() < 1150) begin
			kind = $urandom_range(0, 99);
			len  = $urandom_range(1, 4);
			case (len)
				1: seq_b[0] = 8'($urandom_range(0, ASCII_MAX));
				2: seq_b[0] = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
				3: seq_b[0] = 8'($urandom_range(LEAD2_MAX + 1, LEAD3_MAX));
				default: seq_b[0] = 8'($urandom_range(LEAD3_MAX + 1, LEAD4_MAX));
			endcase
			for (int k = 1; k < 4; k++)
				seq_b[k] = 8'($urandom_range(CONT_MIN, CONT_MAX));
			if (kind < 72) begin
				for (int k = 0; k < len; k++)
					push_byte(seq_b[k], k == len - 1);
			end else if (kind < 80) begin
				// cut short with the flag on an earlier byte
				cut = $urandom_range(0, len - 1);
				for (int k = 0; k <= cut; k++)
					push_byte(seq_b[k], k == cut);
			end else if (kind < 85) begin
				// drop the flag on the last byte
				for (int k = 0; k < len; k++)
					push_byte(seq_b[k], 1'b0);
			end else if (kind < 92) begin
				cut = $urandom_range(0, len - 1);
				seq_b[cut] = 8'($urandom_range(0, 255));
				for (int k = 0; k < len; k++)
					push_byte(seq_b[k], k == len - 1);
			end else begin
				for (int k = 0; k < len; k++)
					push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < stream_bytes.size(); i++) begin
			while (!(i >= 600 && i < 800) && $urandom_range(0, 99) < 26) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte  <= stream_bytes[i];
			seq_end  <= stream_ends[i];
			do @(posedge clk); while (in_stall);
		end
		in_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
